// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks used in the design folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define ASSERT_CLKRST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Checked on every rising edge, reset included.
`define ASSERT_CLK(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// ===== design/rwcp_pkg.sv =====
// ----------------------------------------------------------------------------
// rwcp_pkg
// Types and constants of the RIFF/WAVE chunk parser.
// ----------------------------------------------------------------------------
package rwcp_pkg;

   localparam logic [31:0] ID_RIFF = 32'h5249_4646;
   localparam logic [31:0] ID_WAVE = 32'h5741_5645;
   localparam logic [31:0] ID_FMT  = 32'h666D_7420;
   localparam logic [31:0] ID_DATA = 32'h6461_7461;

   localparam logic [32:0] HEADER_BYTES  = 33'd12;
   localparam logic [31:0] FMT_MIN_BYTES = 32'd16;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_ID,
      PH_SIZE,
      PH_SKIP,
      PH_STOP
   } phase_type;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic        wav_ok;
      logic [31:0] fmt_offset;
      logic [31:0] fmt_length;
      logic [31:0] data_offset;
      logic [31:0] data_length;
   } rsp_payload_type;

endpackage

// ===== design/riff_wave_chunk_parser_core.sv =====
// ----------------------------------------------------------------------------
// riff_wave_chunk_parser_core
// Walks the header and chunks of a WAV file streamed one byte per beat and
// reports where the fmt and data payloads sit.
//
//   Channel  Direction  Handshake        Carries
//   req      in         valid / ready    one file byte and its last flag
//   rsp      out        valid / ready    verdict, offsets and lengths
//   csr      in         write enable     file length in bytes
//
// A single register stage holds the parse state and the result register
// sits behind it, so a byte is accepted each cycle unless the input stalls.
// A result is ready the cycle after the beat that carries the last flag.
// The input stalls only while a result waits and rsp_ready is low.
// Reset is synchronous; the parse state clears again after each result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module riff_wave_chunk_parser_core
   import rwcp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            csr_wr_en,
   input  logic [31:0]     csr_wr_data
);

   logic [31:0]     total_bytes_ff;
   logic [32:0]     position_ff,   position_in;
   phase_type       phase_ff,      phase_in;
   logic            header_bad_ff, header_bad_in;
   logic [31:0]     id_shift_ff,   id_shift_in;
   logic [31:0]     size_shift_ff, size_shift_in;
   logic [1:0]      count_ff,      count_in;
   logic [32:0]     left_ff,       left_in;
   logic            fmt_seen_ff,   fmt_seen_in;
   logic [31:0]     fmt_start_ff,  fmt_start_in;
   logic [31:0]     fmt_len_ff,    fmt_len_in;
   logic            data_seen_ff,  data_seen_in;
   logic [31:0]     data_start_ff, data_start_in;
   logic [31:0]     data_len_ff,   data_len_in;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic        accept;
   logic        in_range;
   logic [32:0] chunk_start;
   logic [33:0] chunk_end;
   logic [32:0] skip_len;
   logic        head_ok;

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign accept      = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign in_range    = position_ff < {1'b0, total_bytes_ff};
   assign chunk_start = position_ff + 33'd1;
   assign chunk_end   = {1'b0, chunk_start} + {2'b00, size_shift_in};
   assign skip_len    = {1'b0, size_shift_in} + {32'd0, size_shift_in[0]};

   // Next parse state for the current byte.
   always_comb begin
      position_in   = (position_ff == '1) ? position_ff : position_ff + 33'd1;
      phase_in      = phase_ff;
      header_bad_in = header_bad_ff;
      id_shift_in   = id_shift_ff;
      size_shift_in = size_shift_ff;
      count_in      = count_ff;
      left_in       = left_ff;
      fmt_seen_in   = fmt_seen_ff;
      fmt_start_in  = fmt_start_ff;
      fmt_len_in    = fmt_len_ff;
      data_seen_in  = data_seen_ff;
      data_start_in = data_start_ff;
      data_len_in   = data_len_ff;
      if (in_range) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (position_ff < 33'd4 ||
                   (position_ff >= 33'd8 && position_ff < HEADER_BYTES)) begin
                  id_shift_in = {id_shift_ff[23:0], req_payload.byte_in};
               end
               if (position_ff == 33'd3 && id_shift_in != ID_RIFF) begin
                  header_bad_in = 1'b1;
               end
               if (position_ff == HEADER_BYTES - 33'd1) begin
                  if (id_shift_in != ID_WAVE) begin
                     header_bad_in = 1'b1;
                  end
                  phase_in    = header_bad_in ? PH_STOP : PH_ID;
                  count_in    = 2'd0;
                  id_shift_in = '0;
               end
            end
            PH_ID: begin
               id_shift_in = {id_shift_ff[23:0], req_payload.byte_in};
               count_in    = count_ff + 2'd1;
               if (count_ff == 2'd3) begin
                  phase_in = PH_SIZE;
               end
            end
            PH_SIZE: begin
               size_shift_in = {req_payload.byte_in, size_shift_ff[31:8]};
               count_in      = count_ff + 2'd1;
               if (count_ff == 2'd3) begin
                  if (chunk_end > {2'b00, total_bytes_ff}) begin
                     phase_in = PH_STOP;
                  end else begin
                     if (id_shift_ff == ID_FMT) begin
                        fmt_seen_in  = 1'b1;
                        fmt_start_in = chunk_start[31:0];
                        fmt_len_in   = size_shift_in;
                     end else if (id_shift_ff == ID_DATA) begin
                        data_seen_in  = 1'b1;
                        data_start_in = chunk_start[31:0];
                        data_len_in   = size_shift_in;
                     end
                     left_in  = skip_len;
                     phase_in = (skip_len == '0) ? PH_ID : PH_SKIP;
                  end
               end
            end
            PH_SKIP: begin
               if (left_ff != '0) begin
                  left_in = left_ff - 33'd1;
               end
               if (left_in == '0) begin
                  phase_in = PH_ID;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Result for a beat that carries the last flag.
   always_comb begin
      head_ok        = phase_in != PH_HEADER && !header_bad_in;
      rsp_payload_in = '0;
      if (head_ok) begin
         rsp_payload_in.wav_ok      = fmt_seen_in && data_seen_in &&
                                      data_len_in != '0 &&
                                      fmt_len_in >= FMT_MIN_BYTES;
         rsp_payload_in.fmt_offset  = fmt_seen_in  ? fmt_start_in  : '0;
         rsp_payload_in.fmt_length  = fmt_seen_in  ? fmt_len_in    : '0;
         rsp_payload_in.data_offset = data_seen_in ? data_start_in : '0;
         rsp_payload_in.data_length = data_seen_in ? data_len_in   : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_bytes_ff <= '0;
      end else if (csr_wr_en) begin
         total_bytes_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_payload.last_byte)) begin
         position_ff   <= '0;
         phase_ff      <= PH_HEADER;
         header_bad_ff <= 1'b0;
         id_shift_ff   <= '0;
         size_shift_ff <= '0;
         count_ff      <= '0;
         left_ff       <= '0;
         fmt_seen_ff   <= 1'b0;
         fmt_start_ff  <= '0;
         fmt_len_ff    <= '0;
         data_seen_ff  <= 1'b0;
         data_start_ff <= '0;
         data_len_ff   <= '0;
      end else if (accept) begin
         position_ff   <= position_in;
         phase_ff      <= phase_in;
         header_bad_ff <= header_bad_in;
         id_shift_ff   <= id_shift_in;
         size_shift_ff <= size_shift_in;
         count_ff      <= count_in;
         left_ff       <= left_in;
         fmt_seen_ff   <= fmt_seen_in;
         fmt_start_ff  <= fmt_start_in;
         fmt_len_ff    <= fmt_len_in;
         data_seen_ff  <= data_seen_in;
         data_start_ff <= data_start_in;
         data_len_ff   <= data_len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && req_payload.last_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_payload.last_byte) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   `ASSERT_CLKRST(a_last_gives_result, clock, reset,
      accept && req_payload.last_byte |=> rsp_valid)
   `ASSERT_CLK(a_no_overwrite, clock,
      rsp_valid_ff && !rsp_ready |-> !req_ready)
   `ASSERT_CLKRST(a_ok_consistent, clock, reset,
      rsp_valid && rsp_payload.wav_ok |->
         (rsp_payload.fmt_length >= FMT_MIN_BYTES && rsp_payload.data_length != '0))
   `ASSERT_CLKRST(a_header_done, clock, reset,
      phase_ff != PH_HEADER |-> position_ff >= HEADER_BYTES)

endmodule

// ===== tb/tb_riff_wave_chunk_parser_core.sv =====
// ----------------------------------------------------------------------------
// tb_riff_wave_chunk_parser_core
// Streams generated WAV files into the chunk parser one byte per beat and
// checks each reported chunk map against a cycle-free model of the parse.
// Files range from well-formed RIFF/WAVE images with fmt, data and other
// chunks to corrupt headers, overrunning chunks, early last bytes and noise.
// The file length register changes between files while the parser is idle,
// and both channels see random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_riff_wave_chunk_parser_core;
   timeunit 1ns;
   timeprecision 1ps;

   import rwcp_pkg::*;

   localparam int unsigned CLOCK_HALF   = 4;
   localparam int unsigned RESET_CYCLES = 12;
   localparam int unsigned STALL_LIMIT  = 3000;
   localparam int unsigned RANDOM_BEATS = 1250;
   localparam logic [32:0] POSITION_MAX = '1;

   class chunk_map_board;
      logic [31:0] total_bytes;
      logic [32:0] byte_position;
      phase_type   phase;
      bit          header_bad;
      logic [31:0] id_shift;
      logic [31:0] size_shift;
      logic [32:0] chunk_left;
      logic [1:0]  chunk_kind;
      bit          fmt_seen;
      logic [31:0] fmt_start;
      logic [31:0] fmt_len;
      bit          data_seen;
      logic [31:0] data_start;
      logic [31:0] data_len;
      rsp_payload_type expected_maps[$];
      int unsigned error_count;

      function new();
         total_bytes  = '0;
         error_count  = 0;
         restart();
      endfunction

      function void restart();
         byte_position = '0;
         phase         = PH_HEADER;
         header_bad    = 1'b0;
         id_shift      = '0;
         size_shift    = '0;
         chunk_left    = '0;
         chunk_kind    = '0;
         fmt_seen      = 1'b0;
         fmt_start     = '0;
         fmt_len       = '0;
         data_seen     = 1'b0;
         data_start    = '0;
         data_len      = '0;
      endfunction

      function void set_total(logic [31:0] value);
         total_bytes = value;
      endfunction

      function void close_chunk_header();
         logic [33:0] chunk_end;
         logic [32:0] skip;
         chunk_end = {1'b0, byte_position} + 34'd1 + {2'b0, size_shift};
         if (chunk_end > {2'b0, total_bytes}) begin
            phase = PH_STOP;
            return;
         end
         chunk_kind = 2'd0;
         if (id_shift == ID_FMT) begin
            chunk_kind = 2'd1;
            fmt_seen   = 1'b1;
            fmt_start  = byte_position[31:0] + 32'd1;
            fmt_len    = size_shift;
         end else if (id_shift == ID_DATA) begin
            chunk_kind = 2'd2;
            data_seen  = 1'b1;
            data_start = byte_position[31:0] + 32'd1;
            data_len   = size_shift;
         end
         skip       = {1'b0, size_shift} + 33'(size_shift[0]);
         chunk_left = skip;
         phase      = (skip == '0) ? PH_ID : PH_SKIP;
      endfunction

      function void walk_byte(logic [7:0] octet);
         case (phase)
            PH_HEADER: begin
               if (byte_position < 33'd4 ||
                   (byte_position >= 33'd8 && byte_position < HEADER_BYTES))
                  id_shift = {id_shift[23:0], octet};
               if (byte_position == 33'd3 && id_shift != ID_RIFF)
                  header_bad = 1'b1;
               if (byte_position == HEADER_BYTES - 33'd1) begin
                  if (id_shift != ID_WAVE)
                     header_bad = 1'b1;
                  phase      = header_bad ? PH_STOP : PH_ID;
                  chunk_left = '0;
                  id_shift   = '0;
               end
            end
            PH_ID: begin
               id_shift = {id_shift[23:0], octet};
               chunk_left++;
               if (chunk_left >= 33'd4) begin
                  chunk_left = '0;
                  phase      = PH_SIZE;
               end
            end
            PH_SIZE: begin
               size_shift = {octet, size_shift[31:8]};
               chunk_left++;
               if (chunk_left >= 33'd4)
                  close_chunk_header();
            end
            PH_SKIP: begin
               if (chunk_left != '0)
                  chunk_left--;
               if (chunk_left == '0)
                  phase = PH_ID;
            end
            default: begin
            end
         endcase
      endfunction

      function void note_byte(req_payload_type beat);
         rsp_payload_type map;
         if (byte_position < {1'b0, total_bytes})
            walk_byte(beat.byte_in);
         if (byte_position != POSITION_MAX)
            byte_position++;
         if (beat.last_byte) begin
            map = '0;
            if (phase != PH_HEADER && !header_bad) begin
               map.wav_ok      = fmt_seen && data_seen && data_len != '0 &&
                                 fmt_len >= FMT_MIN_BYTES;
               map.fmt_offset  = fmt_seen ? fmt_start : '0;
               map.fmt_length  = fmt_seen ? fmt_len : '0;
               map.data_offset = data_seen ? data_start : '0;
               map.data_length = data_seen ? data_len : '0;
            end
            expected_maps.push_back(map);
            restart();
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
         end
      endfunction

      function void check_map(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_maps.size() == 0) begin
            $error("result beat with no file pending");
            error_count++;
            return;
         end
         want = expected_maps.pop_front();
         compare_field("wav_ok", 32'(want.wav_ok), 32'(got.wav_ok));
         compare_field("fmt_offset", want.fmt_offset, got.fmt_offset);
         compare_field("fmt_length", want.fmt_length, got.fmt_length);
         compare_field("data_offset", want.data_offset, got.data_offset);
         compare_field("data_length", want.data_length, got.data_length);
      endfunction
   endclass

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_payload;
   logic            csr_wr_en;
   logic [31:0]     csr_wr_data;

   chunk_map_board board = new();
   logic [7:0]     file_bytes[$];
   bit             quiet_sender;
   int unsigned    beats_sent;
   int unsigned    stall_left;
   int unsigned    open_left;
   int unsigned    quiet_cycles;
   int unsigned    draw;

   riff_wave_chunk_parser_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial clock = 1'b0;
   always #(CLOCK_HALF) clock = ~clock;

   function void append_word(logic [31:0] word);
      for (int i = 3; i >= 0; i--)
         file_bytes.push_back(word[8*i +: 8]);
   endfunction

   function void append_le32(logic [31:0] word);
      for (int i = 0; i < 4; i++)
         file_bytes.push_back(word[8*i +: 8]);
   endfunction

   function void append_random(int unsigned count);
      for (int unsigned i = 0; i < count; i++)
         file_bytes.push_back(8'($urandom()));
   endfunction

   function void build_wav();
      int unsigned shape;
      int unsigned chunk_count;
      int unsigned pick;
      int unsigned spot;
      int unsigned cut;
      logic [31:0] size;
      logic [31:0] id;
      file_bytes.delete();
      shape = $urandom_range(0, 99);
      if (shape < 5) begin
         append_random($urandom_range(1, 30));
         return;
      end
      append_word(ID_RIFF);
      append_random(4);
      append_word(ID_WAVE);
      if (shape < 13) begin
         spot = $urandom_range(0, 7);
         spot = (spot < 4) ? spot : spot + 4;
         file_bytes[spot] ^= 8'($urandom_range(1, 255));
      end
      chunk_count = $urandom_range(0, 3);
      for (int unsigned c = 0; c < chunk_count; c++) begin
         pick = $urandom_range(0, 9);
         if (pick < 3) begin
            id   = ID_FMT;
            size = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : 16;
         end else if (pick < 6) begin
            id   = ID_DATA;
            size = $urandom_range(0, 12);
         end else if (pick < 9) begin
            id   = $urandom();
            size = $urandom_range(0, 9);
         end else begin
            id   = $urandom_range(0, 1) ? ID_FMT : ID_DATA;
            size = $urandom();
            if (size < 32'd64)
               size += 32'd64;
         end
         append_word(id);
         append_le32(size);
         if (pick == 9) begin
            append_random($urandom_range(0, 6));
            break;
         end
         append_random(size + size[0]);
      end
      if ($urandom_range(0, 3) == 0)
         append_random($urandom_range(1, 7));
      if (shape >= 13 && shape < 25) begin
         cut = $urandom_range(1, file_bytes.size());
         while (file_bytes.size() > cut)
            void'(file_bytes.pop_back());
      end
   endfunction

   task automatic send_beat(req_payload_type beat);
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= beat;
      do
         @(posedge clock);
      while (!req_ready);
      board.note_byte(beat);
      beats_sent++;
   endtask

   task automatic send_file();
      req_payload_type beat;
      int unsigned     gap;
      for (int i = 0; i < file_bytes.size(); i++) begin
         beat.byte_in   = file_bytes[i];
         beat.last_byte = (i == file_bytes.size() - 1);
         send_beat(beat);
         draw = $urandom_range(0, 99);
         if (quiet_sender || draw < 60)
            gap = 0;
         else if (draw < 92)
            gap = $urandom_range(1, 3);
         else
            gap = $urandom_range(8, 30);
         if (gap != 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   task automatic write_total(logic [31:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.expected_maps.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      board.set_total(value);
   endtask

   always @(negedge clock) begin
      if (open_left != 0) begin
         open_left--;
         rsp_ready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         draw = $urandom_range(0, 99);
         if (draw < 20)
            stall_left = $urandom_range(1, 3);
         else if (draw < 24)
            stall_left = $urandom_range(10, 40);
         else if (draw < 26)
            open_left = $urandom_range(50, 200);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_map(rsp_payload);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("riff_wave_chunk_parser_core test failed");
            $finish;
         end
      end
   end

   initial begin
      int unsigned file_index;
      logic [31:0] total;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_payload  = '0;
      rsp_ready    = 1'b0;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      quiet_sender = 1'b0;
      beats_sent   = 0;
      stall_left   = 0;
      open_left    = 0;
      quiet_cycles = 0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Every byte lies beyond a zero length, so the header never completes.
      write_total(32'd0);
      file_bytes = '{8'h00, 8'hFF};
      send_file();

      // The file ends before the twelve header bytes are in.
      write_total(32'd5);
      file_bytes.delete();
      append_word(ID_RIFF);
      file_bytes.push_back(8'h00);
      send_file();

      // A full header whose form type is not WAVE.
      write_total(32'd12);
      file_bytes.delete();
      append_word(ID_RIFF);
      append_random(4);
      append_word(ID_WAVE ^ 32'h0000_0001);
      send_file();

      beats_sent = 0;
      file_index = 0;
      while (beats_sent < RANDOM_BEATS) begin
         build_wav();
         if (file_index == 0) begin
            write_total(32'hFFFF_FFFF);
         end else if ($urandom_range(0, 1) == 1) begin
            draw = $urandom_range(0, 9);
            if (draw < 5)
               total = file_bytes.size();
            else if (draw == 5)
               total = (file_bytes.size() > 8) ?
                       file_bytes.size() - $urandom_range(1, 8) : 0;
            else if (draw == 6)
               total = file_bytes.size() + $urandom_range(1, 20);
            else if (draw == 7)
               total = 32'd0;
            else if (draw == 8)
               total = 32'hFFFF_FFFF;
            else
               total = $urandom();
            write_total(total);
         end
         quiet_sender = ($urandom_range(0, 3) == 0);
         send_file();
         file_index++;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (board.expected_maps.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      if (board.error_count == 0)
         $display("riff_wave_chunk_parser_core test passed");
      else
         $display("riff_wave_chunk_parser_core test failed");
      $finish;
   end

endmodule
